// File: sv/rrts_pkg.sv
// Shared types, codes and microcode program of the round-robin thread scheduler.
// No dependencies; the design files refer to this package by scoped names.
package rrts_pkg;

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 16;
    localparam int unsigned CMD_W     = 3;
    localparam logic [7:0]  QUANTUM_LEN_RESET = 8'd10;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_BLOCKED = 2'd3
    } thread_state_t;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_CREATE   = 3'd1,
        CMD_EXIT     = 3'd2,
        CMD_BLOCK    = 3'd3,
        CMD_YIELD    = 3'd4,
        CMD_SCHEDULE = 3'd5
    } cmd_t;

    // Program steps
    typedef enum logic [3:0] {
        U_DISPATCH = 4'd0,
        U_TICK     = 4'd1,
        U_CREATE   = 4'd2,
        U_EXIT     = 4'd3,
        U_BLOCK    = 4'd4,
        U_YIELD    = 4'd5,
        U_SCAN0    = 4'd6,
        U_SCAN     = 4'd7,
        U_NF0      = 4'd8,
        U_NF1      = 4'd9,
        U_CH0      = 4'd10,
        U_CH1      = 4'd11,
        U_CH2      = 4'd12,
        U_EMIT     = 4'd13
    } step_t;

    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_ACCEPT    = 4'd1,
        OP_TICK      = 4'd2,
        OP_CREATE    = 4'd3,
        OP_EXIT      = 4'd4,
        OP_SCAN_INIT = 4'd5,
        OP_SCAN_STEP = 4'd6,
        OP_PICK_IDLE = 4'd7,
        OP_WAKE      = 4'd8,
        OP_SWITCH    = 4'd9,
        OP_EMIT      = 4'd10
    } op_t;

    typedef enum logic [2:0] {
        A_CUR  = 3'd0,
        A_NEXT = 3'd1,
        A_RA   = 3'd2,
        A_USED = 3'd3,
        A_PICK = 3'd4
    } addr_sel_t;

    typedef enum logic [2:0] {
        W_NONE      = 3'd0,
        W_ALWAYS    = 3'd1,
        W_FREE_TID  = 3'd2,
        W_CUR_READY = 3'd3,
        W_DEMOTE    = 3'd4
    } wr_gate_t;

    typedef enum logic [2:0] {
        J_NEXT     = 3'd0,
        J_GOTO     = 3'd1,
        J_DISPATCH = 3'd2,
        J_SCAN     = 3'd3,
        J_IDLE     = 3'd4,
        J_OUT      = 3'd5
    } jump_t;

    typedef struct packed {
        op_t           op;
        addr_sel_t     addr;
        wr_gate_t      wr;
        thread_state_t wdata;
        jump_t         jump;
        step_t         target;
        logic          take;
    } uword_t;

    typedef struct packed {
        logic hit;
        logic exhausted;
        logic idle_valid;
        logic out_free;
    } seq_flags_t;

    function automatic uword_t mk(op_t op, addr_sel_t addr, wr_gate_t wr,
                                  thread_state_t wdata, jump_t jump, step_t target,
                                  logic take);
        uword_t w;
        w.op     = op;
        w.addr   = addr;
        w.wr     = wr;
        w.wdata  = wdata;
        w.jump   = jump;
        w.target = target;
        w.take   = take;
        return w;
    endfunction

    function automatic uword_t ucode(step_t step);
        uword_t w;
        unique case (step)
            U_DISPATCH: w = mk(OP_ACCEPT,    A_CUR,  W_NONE,      ST_EMPTY,   J_DISPATCH,
                               U_DISPATCH, 1'b1);
            U_TICK:     w = mk(OP_TICK,      A_CUR,  W_NONE,      ST_EMPTY,   J_GOTO,
                               U_EMIT, 1'b0);
            U_CREATE:   w = mk(OP_CREATE,    A_USED, W_FREE_TID,  ST_READY,   J_GOTO,
                               U_EMIT, 1'b0);
            U_EXIT:     w = mk(OP_EXIT,      A_CUR,  W_ALWAYS,    ST_EMPTY,   J_GOTO,
                               U_SCAN0, 1'b0);
            U_BLOCK:    w = mk(OP_NOP,       A_CUR,  W_ALWAYS,    ST_BLOCKED, J_GOTO,
                               U_EMIT, 1'b0);
            U_YIELD:    w = mk(OP_NOP,       A_CUR,  W_ALWAYS,    ST_READY,   J_GOTO,
                               U_SCAN0, 1'b0);
            U_SCAN0:    w = mk(OP_SCAN_INIT, A_NEXT, W_NONE,      ST_EMPTY,   J_NEXT,
                               U_SCAN, 1'b0);
            U_SCAN:     w = mk(OP_SCAN_STEP, A_RA,   W_NONE,      ST_EMPTY,   J_SCAN,
                               U_CH0, 1'b0);
            U_NF0:      w = mk(OP_PICK_IDLE, A_CUR,  W_NONE,      ST_EMPTY,   J_IDLE,
                               U_CH1, 1'b0);
            U_NF1:      w = mk(OP_WAKE,      A_CUR,  W_CUR_READY, ST_RUNNING, J_GOTO,
                               U_EMIT, 1'b0);
            U_CH0:      w = mk(OP_NOP,       A_CUR,  W_NONE,      ST_EMPTY,   J_NEXT,
                               U_CH1, 1'b0);
            U_CH1:      w = mk(OP_NOP,       A_CUR,  W_DEMOTE,    ST_READY,   J_NEXT,
                               U_CH2, 1'b0);
            U_CH2:      w = mk(OP_SWITCH,    A_PICK, W_ALWAYS,    ST_RUNNING, J_NEXT,
                               U_EMIT, 1'b0);
            U_EMIT:     w = mk(OP_EMIT,      A_CUR,  W_NONE,      ST_EMPTY,   J_OUT,
                               U_DISPATCH, 1'b0);
            default:    w = mk(OP_NOP,       A_CUR,  W_NONE,      ST_EMPTY,   J_GOTO,
                               U_DISPATCH, 1'b0);
        endcase
        return w;
    endfunction

    // Entry step of each command; unused codes just report
    function automatic step_t dispatch(logic [CMD_W-1:0] code);
        step_t s;
        unique case (cmd_t'(code))
            CMD_TICK:     s = U_TICK;
            CMD_CREATE:   s = U_CREATE;
            CMD_EXIT:     s = U_EXIT;
            CMD_BLOCK:    s = U_BLOCK;
            CMD_YIELD:    s = U_YIELD;
            CMD_SCHEDULE: s = U_SCAN0;
            default:      s = U_EMIT;
        endcase
        return s;
    endfunction

endpackage

// File: sv/round_robin_thread_scheduler_core.sv
// Command flow: tick, create and block run their own step, then the emit step loads m_tvalid;
// unused codes go straight to emit. Exit and yield go on to the ring scan, schedule starts
// from it; the scan reads one slot per cycle through the single port of the state table.
// Throughput: one word in flight, the next taken in the cycle after the result is loaded;
// a result waiting on m_tready holds the next one.
// Reset (aresetn low, synchronous): slot 0 running, others empty, time slice 10.
module round_robin_thread_scheduler_core #(
    parameter int unsigned THREAD_SLOTS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rrts_pkg::S_TDATA_W-1:0]     s_tdata,     // [2:0] command, [3] make_idle
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [3:0] running_tid, [4] switched, [5] yield_request, [9:6] new_tid, [10] status
    output logic [rrts_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [7:0]                         cfg_wr_data   // quantum length in ticks
);
    localparam int unsigned TW = $clog2(THREAD_SLOTS);

    rrts_pkg::uword_t        uw;
    rrts_pkg::seq_flags_t    flags;
    logic                    mem_we;
    logic [TW-1:0]           mem_addr;
    rrts_pkg::thread_state_t mem_wdata;
    rrts_pkg::thread_state_t mem_rdata;

    rrts_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .cmd      (s_tdata[rrts_pkg::CMD_W-1:0]),
        .flags    (flags),
        .uw       (uw),
        .s_tready (s_tready)
    );

    rrts_datapath #(
        .THREAD_SLOTS (THREAD_SLOTS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .uw          (uw),
        .s_tvalid    (s_tvalid),
        .make_idle   (s_tdata[rrts_pkg::CMD_W]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .mem_we      (mem_we),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .mem_rdata   (mem_rdata),
        .flags       (flags)
    );

    rrts_state_mem #(
        .THREAD_SLOTS (THREAD_SLOTS)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (mem_we),
        .addr    (mem_addr),
        .wdata   (mem_wdata),
        .rdata   (mem_rdata)
    );

endmodule

// File: sv/rrts_state_mem.sv
// Thread state table: one write/read port, registered read data, valid bit per slot.
// Uses rrts_pkg for the thread state encoding.
module rrts_state_mem #(
    parameter int unsigned THREAD_SLOTS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              we,
    input  logic [$clog2(THREAD_SLOTS)-1:0]   addr,
    input  rrts_pkg::thread_state_t           wdata,
    output rrts_pkg::thread_state_t           rdata
);
    localparam int unsigned AW = $clog2(THREAD_SLOTS);

    rrts_pkg::thread_state_t slot_mem [THREAD_SLOTS];
    logic [THREAD_SLOTS-1:0] valid_reg;
    rrts_pkg::thread_state_t rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[addr] <= 1'b1;
        end
    end

    // Slot never written reads as its reset value: slot 0 running, others empty
    always_ff @(posedge aclk) begin
        if (we) begin
            slot_mem[addr] <= wdata;
        end
        if (valid_reg[addr]) begin
            rd_reg <= slot_mem[addr];
        end else if (addr == AW'(0)) begin
            rd_reg <= rrts_pkg::ST_RUNNING;
        end else begin
            rd_reg <= rrts_pkg::ST_EMPTY;
        end
    end

    assign rdata = rd_reg;

endmodule

// File: sv/rrts_sequencer.sv
// Microprogram sequencer: step counter, control-store lookup and jump logic.
// Uses rrts_pkg for the program, step codes and control word layout.
module rrts_sequencer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic [rrts_pkg::CMD_W-1:0]      cmd,
    input  rrts_pkg::seq_flags_t            flags,
    output rrts_pkg::uword_t                uw,
    output logic                            s_tready
);
    rrts_pkg::step_t upc_reg, upc_next;
    rrts_pkg::step_t upc_inc;

    assign upc_inc = rrts_pkg::step_t'(upc_reg + 4'd1);

    always_comb begin
        uw       = rrts_pkg::ucode(upc_reg);
        s_tready = uw.take;
    end

    always_comb begin
        upc_next = upc_reg;
        unique case (uw.jump)
            rrts_pkg::J_NEXT:     upc_next = upc_inc;
            rrts_pkg::J_GOTO:     upc_next = uw.target;
            rrts_pkg::J_DISPATCH: begin
                if (s_tvalid) begin
                    upc_next = rrts_pkg::dispatch(cmd);
                end
            end
            // hold on the scan step until a hit or the end of the ring
            rrts_pkg::J_SCAN: begin
                if (flags.hit) begin
                    upc_next = uw.target;
                end else if (flags.exhausted) begin
                    upc_next = upc_inc;
                end
            end
            rrts_pkg::J_IDLE:     upc_next = flags.idle_valid ? uw.target : upc_inc;
            rrts_pkg::J_OUT: begin
                if (flags.out_free) begin
                    upc_next = uw.target;
                end
            end
            default:              upc_next = rrts_pkg::U_DISPATCH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= rrts_pkg::U_DISPATCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

// File: sv/rrts_datapath.sv
// Scheduler datapath: thread registers, quantum, scan pointers and the output word register.
// Driven by control words from rrts_sequencer; uses rrts_pkg types.
module rrts_datapath #(
    parameter int unsigned THREAD_SLOTS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rrts_pkg::uword_t                    uw,
    input  logic                                s_tvalid,
    input  logic                                make_idle,
    input  logic                                cfg_wr_en,
    input  logic [7:0]                          cfg_wr_data,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [rrts_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                mem_we,
    output logic [$clog2(THREAD_SLOTS)-1:0]     mem_addr,
    output rrts_pkg::thread_state_t             mem_wdata,
    input  rrts_pkg::thread_state_t             mem_rdata,
    output rrts_pkg::seq_flags_t                flags
);
    localparam int unsigned TW = $clog2(THREAD_SLOTS);

    logic [TW-1:0] cur_reg,   cur_next;
    logic [TW-1:0] idle_reg,  idle_next;
    logic          idle_valid_reg, idle_valid_next;
    logic [TW:0]   used_reg,  used_next;
    logic [7:0]    quantum_reg, quantum_next;
    logic [7:0]    ts_reg,    ts_next;
    logic [TW-1:0] ra_reg,    ra_next;
    logic [TW-1:0] tidx_reg,  tidx_next;
    logic          tvld_reg,  tvld_next;
    logic [TW-1:0] pick_reg,  pick_next;
    logic          mk_idle_reg, mk_idle_next;
    logic          sw_reg,    sw_next;
    logic          yreq_reg,  yreq_next;
    logic [3:0]    ntid_reg,  ntid_next;
    logic          status_reg, status_next;
    logic          m_valid_reg, m_valid_next;
    logic [rrts_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [TW-1:0]   cur_inc;
    logic [TW-1:0]   cur_inc2;
    logic [TW-1:0]   ra_inc;
    logic [7:0]      q_dec;
    logic            tid_free;
    logic            hit;
    logic            out_free;
    logic [TW+3:0]   cur_ext;
    logic [TW+4:0]   used_ext;

    function automatic logic [TW-1:0] wrap_inc(input logic [TW-1:0] x);
        return (x == TW'(THREAD_SLOTS - 1)) ? '0 : x + TW'(1);
    endfunction

    assign cur_inc  = wrap_inc(cur_reg);
    assign cur_inc2 = wrap_inc(cur_inc);
    assign ra_inc   = wrap_inc(ra_reg);
    assign q_dec    = (quantum_reg == 8'd0) ? 8'd0 : quantum_reg - 8'd1;
    assign tid_free = used_reg < (TW+1)'(THREAD_SLOTS);
    assign hit      = tvld_reg && (tidx_reg != '0) && (tidx_reg != idle_reg)
                      && (mem_rdata == rrts_pkg::ST_READY);
    assign out_free = !m_valid_reg || m_tready;
    assign cur_ext  = (TW+4)'(cur_reg);
    assign used_ext = (TW+5)'(used_reg);

    always_comb begin
        flags.hit        = hit;
        flags.exhausted  = !tvld_reg;
        flags.idle_valid = idle_valid_reg;
        flags.out_free   = out_free;
    end

    // State table port
    always_comb begin
        unique case (uw.addr)
            rrts_pkg::A_CUR:  mem_addr = cur_reg;
            rrts_pkg::A_NEXT: mem_addr = cur_inc;
            rrts_pkg::A_RA:   mem_addr = ra_reg;
            rrts_pkg::A_USED: mem_addr = used_reg[TW-1:0];
            rrts_pkg::A_PICK: mem_addr = pick_reg;
            default:          mem_addr = cur_reg;
        endcase
        unique case (uw.wr)
            rrts_pkg::W_NONE:      mem_we = 1'b0;
            rrts_pkg::W_ALWAYS:    mem_we = 1'b1;
            rrts_pkg::W_FREE_TID:  mem_we = tid_free;
            rrts_pkg::W_CUR_READY: mem_we = (mem_rdata == rrts_pkg::ST_READY);
            rrts_pkg::W_DEMOTE:    mem_we = (pick_reg != cur_reg)
                                            && (mem_rdata == rrts_pkg::ST_RUNNING);
            default:               mem_we = 1'b0;
        endcase
        mem_wdata = uw.wdata;
    end

    always_comb begin
        cur_next        = cur_reg;
        idle_next       = idle_reg;
        idle_valid_next = idle_valid_reg;
        used_next       = used_reg;
        quantum_next    = quantum_reg;
        ts_next         = cfg_wr_en ? cfg_wr_data : ts_reg;
        ra_next         = ra_reg;
        tidx_next       = tidx_reg;
        tvld_next       = tvld_reg;
        pick_next       = pick_reg;
        mk_idle_next    = mk_idle_reg;
        sw_next         = sw_reg;
        yreq_next       = yreq_reg;
        ntid_next       = ntid_reg;
        status_next     = status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;

        unique case (uw.op)
            rrts_pkg::OP_NOP: ;
            rrts_pkg::OP_ACCEPT: begin
                if (s_tvalid) begin
                    mk_idle_next = make_idle;
                    sw_next      = 1'b0;
                    yreq_next    = 1'b0;
                    ntid_next    = 4'd0;
                    status_next  = 1'b0;
                end
            end
            rrts_pkg::OP_TICK: begin
                // init thread is never preempted
                if (cur_reg != '0) begin
                    quantum_next = q_dec;
                    yreq_next    = (q_dec == 8'd0);
                end
            end
            rrts_pkg::OP_CREATE: begin
                if (tid_free) begin
                    used_next = used_reg + (TW+1)'(1);
                    ntid_next = used_ext[3:0];
                    if (mk_idle_reg) begin
                        idle_next       = used_reg[TW-1:0];
                        idle_valid_next = 1'b1;
                    end
                end else begin
                    status_next = 1'b1;
                end
            end
            rrts_pkg::OP_EXIT: begin
                if (idle_valid_reg && (cur_reg == idle_reg)) begin
                    idle_valid_next = 1'b0;
                end
            end
            rrts_pkg::OP_SCAN_INIT: begin
                tidx_next = cur_inc;
                tvld_next = 1'b1;
                ra_next   = cur_inc2;
            end
            rrts_pkg::OP_SCAN_STEP: begin
                // test the slot read last cycle, issue the next read
                if (hit) begin
                    pick_next = tidx_reg;
                end else if (tvld_reg) begin
                    tidx_next = ra_reg;
                    tvld_next = (ra_reg != cur_reg);
                    ra_next   = ra_inc;
                end
            end
            rrts_pkg::OP_PICK_IDLE: begin
                if (idle_valid_reg) begin
                    pick_next = idle_reg;
                end
            end
            rrts_pkg::OP_WAKE: begin
                if (mem_rdata == rrts_pkg::ST_READY) begin
                    quantum_next = ts_reg;
                end
            end
            rrts_pkg::OP_SWITCH: begin
                cur_next     = pick_reg;
                quantum_next = ts_reg;
                sw_next      = 1'b1;
            end
            rrts_pkg::OP_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0, status_reg, ntid_reg, yreq_reg, sw_reg,
                                    cur_ext[3:0]};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg        <= '0;
            idle_reg       <= '0;
            idle_valid_reg <= 1'b0;
            used_reg       <= (TW+1)'(1);
            quantum_reg    <= rrts_pkg::QUANTUM_LEN_RESET;
            ts_reg         <= rrts_pkg::QUANTUM_LEN_RESET;
            tvld_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            cur_reg        <= cur_next;
            idle_reg       <= idle_next;
            idle_valid_reg <= idle_valid_next;
            used_reg       <= used_next;
            quantum_reg    <= quantum_next;
            ts_reg         <= ts_next;
            tvld_reg       <= tvld_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ra_reg      <= ra_next;
        tidx_reg    <= tidx_next;
        pick_reg    <= pick_next;
        mk_idle_reg <= mk_idle_next;
        sw_reg      <= sw_next;
        yreq_reg    <= yreq_next;
        ntid_reg    <= ntid_next;
        status_reg  <= status_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: sv/rrts_checker.sv
// Port-level checks of the scheduler core, attached by bind.
// Depends on round_robin_thread_scheduler_core port names.
module rrts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // result register comes up empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // one word at a time: no accept right after an accept
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted back to back");

    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[10]) |-> (m_tdata[9:6] == 4'd0) && !m_tdata[4])
        else $error("failed create reports a tid or a switch");

    a_excl_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[4] && m_tdata[5]))
        else $error("switch and yield request in one word");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

endmodule

bind round_robin_thread_scheduler_core rrts_checker u_rrts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
